// ===== rtl/core/lamp_mode_brightness_controller_defines.svh =====
// Assertion macros for the lamp mode and brightness controller.
`ifndef LAMP_MODE_BRIGHTNESS_CONTROLLER_DEFINES_SVH
`define LAMP_MODE_BRIGHTNESS_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define LMBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LMBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define LMBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/lmbc_pkg.sv =====
// Shared types and constants of the lamp mode and brightness controller.
package lmbc_pkg;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int KEY_W     = 4;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int RAW_W     = 12;
    localparam int PWM_W     = 7;
    localparam int LEVEL_W   = 3;
    localparam int MODE_W    = 2;
    localparam int CURSOR_W  = 3;
    localparam int PERCENT_W = 7;
    localparam int LOFS_W    = 9;   // clamped light value minus its floor, 0..260

    // Request types
    localparam logic [REQ_W-1:0] REQ_KEY   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLOCK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LIGHT = 2'd2;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_CURSOR = 4'd1;
    localparam logic [KEY_W-1:0] KEY_UP     = 4'd2;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 4'd3;
    localparam logic [KEY_W-1:0] KEY_BRIGHT = 4'd4;
    localparam logic [KEY_W-1:0] KEY_AUTO   = 4'd5;
    localparam logic [KEY_W-1:0] KEY_MANUAL = 4'd6;
    localparam logic [KEY_W-1:0] KEY_READ   = 4'd7;
    localparam logic [KEY_W-1:0] KEY_MOVIE  = 4'd8;

    // Edit cursor positions
    localparam logic [CURSOR_W-1:0] CUR_NONE  = 3'd0;
    localparam logic [CURSOR_W-1:0] CUR_HOUR  = 3'd1;
    localparam logic [CURSOR_W-1:0] CUR_MIN   = 3'd2;
    localparam logic [CURSOR_W-1:0] CUR_SEC   = 3'd3;
    localparam logic [CURSOR_W-1:0] CUR_AHOUR = 3'd4;
    localparam logic [CURSOR_W-1:0] CUR_AMIN  = 3'd5;

    typedef enum logic [MODE_W-1:0] {
        MODE_AUTO   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_READ   = 2'd2,
        MODE_MOVIE  = 2'd3
    } mode_t;

    // Ranges and fixed values
    localparam logic [MIN_W-1:0]   HOUR_TOP       = 6'd23;
    localparam logic [MIN_W-1:0]   MIN_TOP        = 6'd59;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP      = 3'd5;
    localparam logic [LEVEL_W-1:0] LEVEL_READ     = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_MOVIE    = 3'd1;
    localparam logic [HOUR_W-1:0]  ALARM_HOUR_RST = 5'd22;
    localparam logic [MIN_W-1:0]   ALARM_MIN_RST  = 6'd30;
    localparam logic [PWM_W-1:0]   PWM_STEP       = 7'd20;

    // Light scaling: raw/10 via 6554/2^16, then *5/13 via 25210/2^16 (both exact here)
    localparam logic [12:0] RECIP_TEN   = 13'd6554;
    localparam logic [14:0] RECIP_PCT   = 15'd25210;
    localparam logic [8:0]  LIGHT_FLOOR = 9'd100;
    localparam logic [8:0]  LIGHT_CEIL  = 9'd360;

endpackage

// ===== rtl/core/lmbc_if.sv =====
// Request and response channel interfaces of the lamp controller.
interface lmbc_req_if;
    import lmbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [KEY_W-1:0]     key_code;
    logic [HOUR_W-1:0]    clock_hour;
    logic [MIN_W-1:0]     clock_minute;
    logic [MIN_W-1:0]     clock_second;
    logic [RAW_W-1:0]     light_raw;

    modport source (output valid, req_type, key_code, clock_hour, clock_minute,
                    clock_second, light_raw, input ready);
    modport sink   (input valid, req_type, key_code, clock_hour, clock_minute,
                    clock_second, light_raw, output ready);
endinterface

interface lmbc_rsp_if;
    import lmbc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PWM_W-1:0]     pwm_compare;
    logic [LEVEL_W-1:0]   bright_level;
    logic [MODE_W-1:0]    lamp_mode;
    logic [CURSOR_W-1:0]  edit_cursor;
    logic [HOUR_W-1:0]    wake_hour;
    logic [MIN_W-1:0]     wake_minute;
    logic                 off_latched;
    logic                 time_write;
    logic [HOUR_W-1:0]    new_hour;
    logic [MIN_W-1:0]     new_minute;
    logic [MIN_W-1:0]     new_second;
    logic [PERCENT_W-1:0] light_percent;

    modport source (output valid, pwm_compare, bright_level, lamp_mode, edit_cursor,
                    wake_hour, wake_minute, off_latched, time_write, new_hour,
                    new_minute, new_second, light_percent, input ready);
    modport sink   (input valid, pwm_compare, bright_level, lamp_mode, edit_cursor,
                    wake_hour, wake_minute, off_latched, time_write, new_hour,
                    new_minute, new_second, light_percent, output ready);
endinterface

// ===== rtl/core/lamp_mode_brightness_controller.sv =====
// Lamp mode and brightness controller: key, clock and light words in, lamp state words out.
//
//   channel | dir | word carries
//   --------+-----+----------------------------------------------------------
//   req     | in  | req_type, key_code, clock time, raw light sample
//   rsp     | out | pwm value, level, mode, cursor, alarm, latch, clock write, percent
//
// Every req word gives exactly one rsp word showing the state after that word.
// An input register (the light sample is already divided by ten and clamped there)
// feeds one pass of state update logic into the result register.
// A new req word is taken every cycle while rsp keeps flowing; req.ready falls
// only when the input register is full and the result register is stalled.
// Asynchronous active-low reset puts the lamp in auto mode, level 0, alarm 22:30.
`include "lamp_mode_brightness_controller_defines.svh"

module lamp_mode_brightness_controller (
    input  logic        clk,
    input  logic        rst_n,
    lmbc_req_if.sink    req,
    lmbc_rsp_if.source  rsp
);
    import lmbc_pkg::*;

    // Step a field up by one; past the top it wraps to zero.
    function automatic logic [MIN_W-1:0] wrap_up(input logic [MIN_W-1:0] v,
                                                 input logic [MIN_W-1:0] top);
        logic [MIN_W:0] s;
        s = {1'b0, v} + {{MIN_W{1'b0}}, 1'b1};
        return (s > {1'b0, top}) ? '0 : s[MIN_W-1:0];
    endfunction

    // Step a field down by one; from zero or an out-of-range value go to the top.
    function automatic logic [MIN_W-1:0] wrap_down(input logic [MIN_W-1:0] v,
                                                   input logic [MIN_W-1:0] top);
        logic [MIN_W-1:0] d;
        d = v - {{(MIN_W-1){1'b0}}, 1'b1};
        return (v == '0 || d > top) ? top : d;
    endfunction

    // Auto-mode brightness: darker room, brighter lamp.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [PERCENT_W-1:0] p);
        logic [LEVEL_W-1:0] l;
        if (p <= 7'd10)      l = 3'd5;
        else if (p <= 7'd30) l = 3'd4;
        else if (p <= 7'd50) l = 3'd3;
        else if (p <= 7'd70) l = 3'd2;
        else if (p <= 7'd90) l = 3'd1;
        else                 l = 3'd0;
        return l;
    endfunction

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic [REQ_W-1:0]      s1_req_reg;
    logic [KEY_W-1:0]      s1_key_reg;
    logic [HOUR_W-1:0]     s1_hour_reg;
    logic [MIN_W-1:0]      s1_min_reg;
    logic [MIN_W-1:0]      s1_sec_reg;
    logic [LOFS_W-1:0]     s1_lofs_reg;
    logic [LOFS_W-1:0]     lofs_next;

    logic                  rsp_valid_reg;
    logic                  s1_adv;
    logic                  req_fire;

    // Result register may load when it is empty or being drained this cycle.
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req.valid && req.ready;

    // raw/10 by reciprocal, then clamp to the working range and drop the floor.
    logic [24:0] tenth_prod;
    logic [8:0]  tenth;
    always_comb
    begin
        tenth_prod = {13'd0, req.light_raw} * {12'd0, RECIP_TEN};
        tenth      = tenth_prod[24:16];
        if (tenth < LIGHT_FLOOR)
            lofs_next = '0;
        else if (tenth > LIGHT_CEIL)
            lofs_next = LIGHT_CEIL - LIGHT_FLOOR;
        else
            lofs_next = tenth - LIGHT_FLOOR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg  <= req.req_type;
            s1_key_reg  <= req.key_code;
            s1_hour_reg <= req.clock_hour;
            s1_min_reg  <= req.clock_minute;
            s1_sec_reg  <= req.clock_second;
            s1_lofs_reg <= lofs_next;
        end
    end

    // ------------------------------------------------------------------
    // Lamp state
    // ------------------------------------------------------------------
    mode_t                 mode_reg,         mode_next;
    logic [LEVEL_W-1:0]    level_reg,        level_next;
    logic [CURSOR_W-1:0]   cursor_reg,       cursor_next;
    logic [HOUR_W-1:0]     alarm_hour_reg,   alarm_hour_next;
    logic [MIN_W-1:0]      alarm_minute_reg, alarm_minute_next;
    logic                  latch_reg,        latch_next;
    logic [PERCENT_W-1:0]  percent_reg,      percent_next;

    // Result-only fields
    logic [PWM_W-1:0]      pwm_reg,          pwm_next;
    logic                  tw_reg,           tw_next;
    logic [HOUR_W-1:0]     nh_reg,           nh_next;
    logic [MIN_W-1:0]      nm_reg,           nm_next;
    logic [MIN_W-1:0]      ns_reg,           ns_next;

    // One shared up/down stepper serves whichever field the cursor selects.
    logic [MIN_W-1:0]      edit_val;
    logic [MIN_W-1:0]      edit_top;
    logic [MIN_W-1:0]      edit_res;
    logic [22:0]           pct_prod;
    logic [PERCENT_W-1:0]  pct_new;

    always_comb
    begin
        case (cursor_reg)
            CUR_HOUR:  edit_val = {1'b0, s1_hour_reg};
            CUR_MIN:   edit_val = s1_min_reg;
            CUR_SEC:   edit_val = s1_sec_reg;
            CUR_AHOUR: edit_val = {1'b0, alarm_hour_reg};
            CUR_AMIN:  edit_val = alarm_minute_reg;
            default:   edit_val = '0;
        endcase
        edit_top = (cursor_reg == CUR_HOUR || cursor_reg == CUR_AHOUR) ? HOUR_TOP : MIN_TOP;
        edit_res = (s1_key_reg == KEY_UP) ? wrap_up(edit_val, edit_top)
                                          : wrap_down(edit_val, edit_top);

        // percent = floor(offset*5/13) by reciprocal
        pct_prod = {14'd0, s1_lofs_reg} * {8'd0, RECIP_PCT};
        pct_new  = pct_prod[22:16];
    end

    always_comb
    begin
        mode_next         = mode_reg;
        level_next        = level_reg;
        cursor_next       = cursor_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        latch_next        = latch_reg;
        percent_next      = percent_reg;
        tw_next           = 1'b0;
        nh_next           = '0;
        nm_next           = '0;
        ns_next           = '0;

        case (s1_req_reg)
            REQ_KEY:
            begin
                case (s1_key_reg)
                    KEY_CURSOR:
                    begin
                        cursor_next = (cursor_reg == CUR_AMIN) ? CUR_NONE
                                                               : cursor_reg + 3'd1;
                    end
                    KEY_UP, KEY_DOWN:
                    begin
                        case (cursor_reg)
                            CUR_HOUR, CUR_MIN, CUR_SEC:
                            begin
                                // Report the edited clock time; other fields pass as sampled.
                                tw_next = 1'b1;
                                nh_next = (cursor_reg == CUR_HOUR) ? edit_res[HOUR_W-1:0]
                                                                   : s1_hour_reg;
                                nm_next = (cursor_reg == CUR_MIN) ? edit_res : s1_min_reg;
                                ns_next = (cursor_reg == CUR_SEC) ? edit_res : s1_sec_reg;
                            end
                            CUR_AHOUR: alarm_hour_next   = edit_res[HOUR_W-1:0];
                            CUR_AMIN:  alarm_minute_next = edit_res;
                            default:   ;
                        endcase
                    end
                    KEY_BRIGHT:
                    begin
                        if (mode_reg == MODE_MANUAL && !latch_reg)
                            level_next = (level_reg == LEVEL_TOP) ? '0 : level_reg + 3'd1;
                    end
                    KEY_AUTO:   mode_next = MODE_AUTO;
                    KEY_MANUAL: mode_next = MODE_MANUAL;
                    KEY_READ:
                    begin
                        mode_next = MODE_READ;
                        if (!latch_reg)
                            level_next = LEVEL_READ;
                    end
                    KEY_MOVIE:
                    begin
                        mode_next = MODE_MOVIE;
                        if (!latch_reg)
                            level_next = LEVEL_MOVIE;
                    end
                    default: ;
                endcase
            end
            REQ_CLOCK:
            begin
                // Alarm hit: hold the lamp off until reset.
                if (s1_hour_reg == alarm_hour_reg && s1_min_reg == alarm_minute_reg)
                begin
                    latch_next = 1'b1;
                    level_next = '0;
                end
            end
            REQ_LIGHT:
            begin
                percent_next = pct_new;
                if (mode_reg == MODE_AUTO && !latch_reg)
                    level_next = level_of(pct_new);
            end
            default: ;
        endcase

        pwm_next = PWM_STEP * {4'd0, level_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_AUTO;
            level_reg        <= '0;
            cursor_reg       <= CUR_NONE;
            alarm_hour_reg   <= ALARM_HOUR_RST;
            alarm_minute_reg <= ALARM_MIN_RST;
            latch_reg        <= 1'b0;
            percent_reg      <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                mode_reg         <= mode_next;
                level_reg        <= level_next;
                cursor_reg       <= cursor_next;
                alarm_hour_reg   <= alarm_hour_next;
                alarm_minute_reg <= alarm_minute_next;
                latch_reg        <= latch_next;
                percent_reg      <= percent_next;
            end
            // Load on advance, drop once taken, hold while stalled.
            if (s1_adv)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pwm_reg <= pwm_next;
            tw_reg  <= tw_next;
            nh_reg  <= nh_next;
            nm_reg  <= nm_next;
            ns_reg  <= ns_next;
        end
    end

    // State changes only when the result register reloads, so the state
    // registers always match the word on display.
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.pwm_compare   = pwm_reg;
    assign rsp.bright_level  = level_reg;
    assign rsp.lamp_mode     = mode_reg;
    assign rsp.edit_cursor   = cursor_reg;
    assign rsp.wake_hour     = alarm_hour_reg;
    assign rsp.wake_minute   = alarm_minute_reg;
    assign rsp.off_latched   = latch_reg;
    assign rsp.time_write    = tw_reg;
    assign rsp.new_hour      = nh_reg;
    assign rsp.new_minute    = nm_reg;
    assign rsp.new_second    = ns_reg;
    assign rsp.light_percent = percent_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LMBC_ASSERT_NEXT(a_latch_sticky, clk, rst_n, latch_reg, latch_reg,
        "off latch cleared without reset")
    `LMBC_ASSERT_IMPLY(a_level_range, clk, rst_n, 1'b1, level_reg <= LEVEL_TOP,
        "brightness level out of range")
    `LMBC_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, rsp_valid_reg && !rsp.ready,
        $stable(level_reg) && $stable(mode_reg) && $stable(cursor_reg),
        "lamp state changed while result stalled")
    `LMBC_ASSERT_IMPLY(a_write_fields_zero, clk, rst_n, rsp_valid_reg && !tw_reg,
        nh_reg == '0 && nm_reg == '0 && ns_reg == '0,
        "clock write fields set without time write")

endmodule

// ===== sim/tb.sv =====
// Testbench for the lamp mode and brightness controller: directed and random words, self-checked.
`timescale 1ns / 1ps

module tb;
    import lmbc_pkg::*;

    // Codes that the block has no name for: it must ignore them and keep its state.
    localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
    localparam logic [KEY_W-1:0] KEY_SPARE = 4'd15;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    // Cycles that pass after the last status word before the verdict (two-stage pipe).
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 5000;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key_code;
        logic [HOUR_W-1:0] clock_hour;
        logic [MIN_W-1:0] clock_minute;
        logic [MIN_W-1:0] clock_second;
        logic [RAW_W-1:0] light_raw;
    } lamp_req_t;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_compare;
        logic [LEVEL_W-1:0] bright_level;
        logic [MODE_W-1:0] lamp_mode;
        logic [CURSOR_W-1:0] edit_cursor;
        logic [HOUR_W-1:0] wake_hour;
        logic [MIN_W-1:0] wake_minute;
        logic off_latched;
        logic time_write;
        logic [HOUR_W-1:0] new_hour;
        logic [MIN_W-1:0] new_minute;
        logic [MIN_W-1:0] new_second;
        logic [PERCENT_W-1:0] light_percent;
    } lamp_status_t;

    logic clk;
    logic rst_n;

    lmbc_req_if req_if ();
    lmbc_rsp_if rsp_if ();

    lamp_mode_brightness_controller dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    // Predicted lamp state, advanced once per accepted request word.
    mode_t                mode_q;
    logic [LEVEL_W-1:0]   level_q;
    logic [CURSOR_W-1:0]  cursor_q;
    logic [HOUR_W-1:0]    alarm_hour_q;
    logic [MIN_W-1:0]     alarm_min_q;
    logic                 latch_q;
    logic [PERCENT_W-1:0] percent_q;

    // Status words predicted but not yet seen on the response channel, oldest first.
    lamp_status_t lamp_status_due[$];

    int unsigned mismatch_count;

    // Idling controls: the sender and the receiver each draw a random wait per word
    // while their flag is set. A nonzero hold makes the receiver stall that many cycles.
    bit          req_idle_on;
    bit          rsp_idle_on;
    int unsigned rsp_hold_cycles;

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Step a clock or alarm field by one, wrapping inside 0..top. A value already above
    // top steps up to 0 and down to top.
    function automatic int unsigned wrap_step(int unsigned v, int unsigned top, bit up);
        if (up)
            return (v + 1 > top) ? 0 : v + 1;
        if (v == 0 || v - 1 > top)
            return top;
        return v - 1;
    endfunction

    // Advance the predicted lamp state by one request word and return the status word
    // that the block must answer with.
    function automatic lamp_status_t advance_lamp(lamp_req_t w);
        lamp_status_t r;
        bit           up;
        int unsigned  a;
        r = '0;
        case (w.req_type)
            REQ_KEY:
            begin
                case (w.key_code)
                    KEY_CURSOR:
                        cursor_q = (cursor_q == CUR_AMIN) ? CUR_NONE : cursor_q + 1'b1;
                    KEY_UP, KEY_DOWN:
                    begin
                        up = (w.key_code == KEY_UP);
                        case (cursor_q)
                            CUR_HOUR, CUR_MIN, CUR_SEC:
                            begin
                                // Pass the sampled time on, with the chosen field stepped.
                                r.time_write = 1'b1;
                                r.new_hour   = w.clock_hour;
                                r.new_minute = w.clock_minute;
                                r.new_second = w.clock_second;
                                if (cursor_q == CUR_HOUR)
                                    r.new_hour = HOUR_W'(wrap_step(w.clock_hour, HOUR_TOP, up));
                                else if (cursor_q == CUR_MIN)
                                    r.new_minute =
                                        MIN_W'(wrap_step(w.clock_minute, MIN_TOP, up));
                                else
                                    r.new_second =
                                        MIN_W'(wrap_step(w.clock_second, MIN_TOP, up));
                            end
                            CUR_AHOUR:
                                alarm_hour_q = HOUR_W'(wrap_step(alarm_hour_q, HOUR_TOP, up));
                            CUR_AMIN:
                                alarm_min_q = MIN_W'(wrap_step(alarm_min_q, MIN_TOP, up));
                            default: ;
                        endcase
                    end
                    KEY_BRIGHT:
                        if (mode_q == MODE_MANUAL && !latch_q)
                            level_q = (level_q == LEVEL_TOP) ? '0 : level_q + 1'b1;
                    KEY_AUTO:   mode_q = MODE_AUTO;
                    KEY_MANUAL: mode_q = MODE_MANUAL;
                    KEY_READ:
                    begin
                        mode_q = MODE_READ;
                        if (!latch_q)
                            level_q = LEVEL_READ;
                    end
                    KEY_MOVIE:
                    begin
                        mode_q = MODE_MOVIE;
                        if (!latch_q)
                            level_q = LEVEL_MOVIE;
                    end
                    default: ;
                endcase
            end
            REQ_CLOCK:
                // Alarm time reached: latch the lamp off for good.
                if (w.clock_hour == alarm_hour_q && w.clock_minute == alarm_min_q)
                begin
                    latch_q = 1'b1;
                    level_q = '0;
                end
            REQ_LIGHT:
            begin
                a = w.light_raw / 10;
                if (a < LIGHT_FLOOR)
                    a = LIGHT_FLOOR;
                if (a > LIGHT_CEIL)
                    a = LIGHT_CEIL;
                percent_q = PERCENT_W'(((a - LIGHT_FLOOR) * 5) / 13);
                // Darker room, brighter lamp.
                if (mode_q == MODE_AUTO && !latch_q)
                begin
                    if (percent_q <= 10)
                        level_q = 3'd5;
                    else if (percent_q <= 30)
                        level_q = 3'd4;
                    else if (percent_q <= 50)
                        level_q = 3'd3;
                    else if (percent_q <= 70)
                        level_q = 3'd2;
                    else if (percent_q <= 90)
                        level_q = 3'd1;
                    else
                        level_q = 3'd0;
                end
            end
            default: ;
        endcase
        r.pwm_compare   = PWM_STEP * level_q;
        r.bright_level  = level_q;
        r.lamp_mode     = mode_q;
        r.edit_cursor   = cursor_q;
        r.wake_hour     = alarm_hour_q;
        r.wake_minute   = alarm_min_q;
        r.off_latched   = latch_q;
        r.light_percent = percent_q;
        return r;
    endfunction

    // Word builders; fields the block ignores for that kind carry random bits.
    function automatic lamp_req_t key_word(logic [KEY_W-1:0] k, int unsigned h,
                                           int unsigned m, int unsigned s);
        lamp_req_t w;
        w.req_type     = REQ_KEY;
        w.key_code     = k;
        w.clock_hour   = HOUR_W'(h);
        w.clock_minute = MIN_W'(m);
        w.clock_second = MIN_W'(s);
        w.light_raw    = RAW_W'($urandom_range(0, 4095));
        return w;
    endfunction

    function automatic lamp_req_t clock_word(int unsigned h, int unsigned m);
        lamp_req_t w;
        w.req_type     = REQ_CLOCK;
        w.key_code     = KEY_W'($urandom_range(0, 15));
        w.clock_hour   = HOUR_W'(h);
        w.clock_minute = MIN_W'(m);
        w.clock_second = MIN_W'($urandom_range(0, 63));
        w.light_raw    = RAW_W'($urandom_range(0, 4095));
        return w;
    endfunction

    function automatic lamp_req_t light_word(int unsigned raw);
        lamp_req_t w;
        w.req_type     = REQ_LIGHT;
        w.key_code     = KEY_W'($urandom_range(0, 15));
        w.clock_hour   = HOUR_W'($urandom_range(0, 31));
        w.clock_minute = MIN_W'($urandom_range(0, 63));
        w.clock_second = MIN_W'($urandom_range(0, 63));
        w.light_raw    = RAW_W'(raw);
        return w;
    endfunction

    // Mostly well-formed keys and samples, the rest noise over the full field widths.
    // Unless alarm_ok is set, keep clock samples off the alarm time so the latch stays clear.
    function automatic lamp_req_t random_word(bit alarm_ok);
        lamp_req_t   w;
        int unsigned pick;
        pick           = $urandom_range(0, 99);
        w.req_type     = REQ_KEY;
        w.key_code     = KEY_W'($urandom_range(KEY_CURSOR, KEY_MOVIE));
        w.clock_hour   = HOUR_W'($urandom_range(0, HOUR_TOP));
        w.clock_minute = MIN_W'($urandom_range(0, MIN_TOP));
        w.clock_second = MIN_W'($urandom_range(0, MIN_TOP));
        w.light_raw    = RAW_W'($urandom_range(0, 4095));
        if (pick >= 55 && pick < 70)
            w.req_type = REQ_CLOCK;
        else if (pick >= 70 && pick < 88)
            w.req_type = REQ_LIGHT;
        else if (pick >= 88)
        begin
            w.req_type     = REQ_W'($urandom_range(0, 3));
            w.key_code     = KEY_W'($urandom_range(0, 15));
            w.clock_hour   = HOUR_W'($urandom_range(0, 31));
            w.clock_minute = MIN_W'($urandom_range(0, 63));
            w.clock_second = MIN_W'($urandom_range(0, 63));
        end
        if (w.req_type == REQ_CLOCK)
        begin
            if (alarm_ok && $urandom_range(0, 3) == 0)
            begin
                w.clock_hour   = alarm_hour_q;
                w.clock_minute = alarm_min_q;
            end
            else if (!alarm_ok && w.clock_hour == alarm_hour_q && w.clock_minute == alarm_min_q)
                w.clock_minute[0] = ~w.clock_minute[0];
        end
        return w;
    endfunction

    // Offer one request word after a drawn gap, hold it until taken, then predict.
    // Valid stays high on return so back-to-back words need no extra edge.
    task automatic send_word(lamp_req_t w);
        int unsigned gap;
        gap = req_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= w.req_type;
        req_if.key_code     <= w.key_code;
        req_if.clock_hour   <= w.clock_hour;
        req_if.clock_minute <= w.clock_minute;
        req_if.clock_second <= w.clock_second;
        req_if.light_raw    <= w.light_raw;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        lamp_status_due.push_back(advance_lamp(w));
    endtask

    // Drop valid and hold the sender until every predicted status word has come back.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (lamp_status_due.size() != 0);
    endtask

    // Walk the cursor to a random field, then press one direction many times in a row,
    // so the alarm fields can run through their wrap points.
    task automatic edit_burst();
        logic [CURSOR_W-1:0] target;
        logic [KEY_W-1:0]    dir;
        int unsigned         presses;
        target  = CURSOR_W'($urandom_range(CUR_HOUR, CUR_AMIN));
        dir     = $urandom_range(0, 1) ? KEY_UP : KEY_DOWN;
        presses = $urandom_range(10, 40);
        while (cursor_q != target)
            send_word(key_word(KEY_CURSOR, $urandom_range(0, 23), $urandom_range(0, 59),
                               $urandom_range(0, 59)));
        repeat (presses)
            send_word(key_word(dir, $urandom_range(0, 31), $urandom_range(0, 63),
                               $urandom_range(0, 63)));
    endtask

    task automatic compare_field(string label, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Match one status word from the block against the oldest prediction.
    task automatic check_status(lamp_status_t got);
        lamp_status_t want;
        if (lamp_status_due.size() == 0)
        begin
            $display("%0t: status word expected none actual %h", $time, got);
            mismatch_count++;
            return;
        end
        want = lamp_status_due.pop_front();
        compare_field("pwm_compare", want.pwm_compare, got.pwm_compare);
        compare_field("bright_level", want.bright_level, got.bright_level);
        compare_field("lamp_mode", want.lamp_mode, got.lamp_mode);
        compare_field("edit_cursor", want.edit_cursor, got.edit_cursor);
        compare_field("wake_hour", want.wake_hour, got.wake_hour);
        compare_field("wake_minute", want.wake_minute, got.wake_minute);
        compare_field("off_latched", want.off_latched, got.off_latched);
        compare_field("time_write", want.time_write, got.time_write);
        compare_field("new_hour", want.new_hour, got.new_hour);
        compare_field("new_minute", want.new_minute, got.new_minute);
        compare_field("new_second", want.new_second, got.new_second);
        compare_field("light_percent", want.light_percent, got.light_percent);
    endtask

    // Take every status word the moment valid and ready meet at an edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_status({rsp_if.pwm_compare, rsp_if.bright_level, rsp_if.lamp_mode,
                          rsp_if.edit_cursor, rsp_if.wake_hour, rsp_if.wake_minute,
                          rsp_if.off_latched, rsp_if.time_write, rsp_if.new_hour,
                          rsp_if.new_minute, rsp_if.new_second, rsp_if.light_percent});
    end

    // Receiver: stall a drawn number of cycles before each word, or for a requested
    // long stretch, then hold ready until a word is taken.
    initial
    begin : rsp_receiver
        int unsigned stall;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                stall = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            else
                stall = rsp_idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
        end
    end

    // First word after reset shows the reset state; unknown keys and the spare request
    // type must leave everything as it was.
    task automatic test_reset_and_ignored();
        send_word(key_word(KEY_NONE, 12, 30, 0));
        send_word(key_word(KEY_SPARE, 31, 63, 63));
        send_word(clock_word(22, 29));
        begin : spare_req
            lamp_req_t w;
            w = random_word(1'b0);
            w.req_type = REQ_SPARE;
            send_word(w);
        end
    endtask

    // Light extremes and the edge between level 5 and level 4, in auto mode.
    task automatic test_light_levels();
        send_word(light_word(0));
        send_word(light_word(4095));
        send_word(light_word(1269));
        send_word(light_word(1290));
    endtask

    // Read and movie set fixed levels; the brightness key wraps only in manual mode.
    task automatic test_modes_and_brightness();
        send_word(key_word(KEY_READ, 0, 0, 0));
        send_word(key_word(KEY_MANUAL, 0, 0, 0));
        send_word(key_word(KEY_BRIGHT, 0, 0, 0));
        send_word(key_word(KEY_BRIGHT, 0, 0, 0));
        send_word(key_word(KEY_MOVIE, 0, 0, 0));
        send_word(key_word(KEY_BRIGHT, 0, 0, 0));
        send_word(light_word(2500));
        send_word(key_word(KEY_AUTO, 0, 0, 0));
    endtask

    // Clock field edits wrap at both ends and pass the other two fields through.
    task automatic test_clock_edit();
        send_word(key_word(KEY_UP, 10, 20, 30));
        send_word(key_word(KEY_CURSOR, 10, 20, 30));
        send_word(key_word(KEY_UP, 23, 7, 41));
        send_word(key_word(KEY_DOWN, 0, 59, 59));
        send_word(key_word(KEY_CURSOR, 0, 0, 0));
        send_word(key_word(KEY_UP, 5, 59, 12));
        send_word(key_word(KEY_DOWN, 31, 0, 63));
        send_word(key_word(KEY_CURSOR, 0, 0, 0));
        send_word(key_word(KEY_UP, 8, 9, 63));
        send_word(key_word(KEY_DOWN, 17, 33, 0));
    endtask

    // Alarm hour wraps past 23; alarm minute steps; the cursor wraps back to none.
    task automatic test_alarm_edit();
        send_word(key_word(KEY_CURSOR, 0, 0, 0));
        send_word(key_word(KEY_UP, 0, 0, 0));
        send_word(key_word(KEY_UP, 0, 0, 0));
        send_word(key_word(KEY_CURSOR, 0, 0, 0));
        send_word(key_word(KEY_DOWN, 0, 0, 0));
        send_word(key_word(KEY_CURSOR, 0, 0, 0));
    endtask

    // Bulk random traffic with the latch kept clear; idling switches on and off in stretches.
    task automatic test_random_traffic(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
            begin
                req_idle_on = ($urandom_range(0, 3) != 0);
                rsp_idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) == 0)
                edit_burst();
            else
                send_word(random_word(1'b0));
        end
    endtask

    // Receiver stalls a long stretch while the sender keeps offering words back to back,
    // so the pipe fills and request ready drops; then the sender waits for a full drain.
    task automatic test_backpressure();
        req_idle_on     = 1'b0;
        rsp_idle_on     = 1'b0;
        rsp_hold_cycles = 80;
        repeat (20) send_word(random_word(1'b0));
        wait_drained();
    endtask

    // Near misses, then the alarm time itself; after that nothing may raise the level.
    task automatic test_alarm_latch();
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        send_word(clock_word(alarm_hour_q, alarm_min_q ^ 6'd1));
        send_word(clock_word(alarm_hour_q ^ 5'd1, alarm_min_q));
        send_word(clock_word(alarm_hour_q, alarm_min_q));
        send_word(key_word(KEY_READ, 0, 0, 0));
        send_word(key_word(KEY_MOVIE, 0, 0, 0));
        send_word(key_word(KEY_MANUAL, 0, 0, 0));
        send_word(key_word(KEY_BRIGHT, 0, 0, 0));
        send_word(key_word(KEY_AUTO, 0, 0, 0));
        send_word(light_word(0));
        repeat (150) send_word(random_word(1'b1));
    endtask

    initial
    begin : main_sequence
        int unsigned waited;
        // Drive every input to a known value while reset is held, then release reset.
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = '0;
        req_if.key_code     = '0;
        req_if.clock_hour   = '0;
        req_if.clock_minute = '0;
        req_if.clock_second = '0;
        req_if.light_raw    = '0;
        mismatch_count      = 0;
        rsp_hold_cycles     = 0;
        req_idle_on         = 1'b1;
        rsp_idle_on         = 1'b1;
        mode_q              = MODE_AUTO;
        level_q             = '0;
        cursor_q            = CUR_NONE;
        alarm_hour_q        = ALARM_HOUR_RST;
        alarm_min_q         = ALARM_MIN_RST;
        latch_q             = 1'b0;
        percent_q           = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_and_ignored();
        test_light_levels();
        test_modes_and_brightness();
        test_clock_edit();
        test_alarm_edit();
        test_random_traffic(450);
        test_backpressure();
        test_random_traffic(450);
        wait_drained();
        test_alarm_latch();

        // Let the last words come back, bounded, then give any stray word time to show.
        req_if.valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (lamp_status_due.size() != 0 && waited < DRAIN_LIMIT);
        if (lamp_status_due.size() != 0)
        begin
            $display("%0t: status words expected %0d more actual 0",
                     $time, lamp_status_due.size());
            mismatch_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
